// ----- rtl/bezp_pkg.sv -----
// ----------------------------------------------------------------------------
// bezp_pkg
// shared types, widths and register indexes of the bezier point evaluator
// ----------------------------------------------------------------------------
package bezp_pkg;

  // coordinate and parameter formats
  localparam int COORD_W  = 16;              // signed q8.8
  localparam int T_FRAC   = 16;              // fraction bits of t
  localparam int T_W      = T_FRAC + 1;      // t includes the 1.0 code
  localparam int DIFF_W   = COORD_W + 1;     // b - a
  localparam int PROD_W   = DIFF_W + T_W + 1;
  localparam int SHIFT_W  = PROD_W - T_FRAC; // rounded product
  localparam int SUM_W    = SHIFT_W + 1;     // a + rounded product

  // register file
  localparam int NUM_REGS = 8;
  localparam int IDX_W    = $clog2(NUM_REGS);
  localparam int ADDR_W   = IDX_W + 2;
  localparam int PDATA_W  = 32;

  localparam logic [IDX_W-1:0] REG_START_X = 3'd0;
  localparam logic [IDX_W-1:0] REG_START_Y = 3'd1;
  localparam logic [IDX_W-1:0] REG_CTRL1_X = 3'd2;
  localparam logic [IDX_W-1:0] REG_CTRL1_Y = 3'd3;
  localparam logic [IDX_W-1:0] REG_CTRL2_X = 3'd4;
  localparam logic [IDX_W-1:0] REG_CTRL2_Y = 3'd5;
  localparam logic [IDX_W-1:0] REG_END_X   = 3'd6;
  localparam logic [IDX_W-1:0] REG_END_Y   = 3'd7;

  // pipeline depth: three lerp levels, each a multiply and a round/add stage
  localparam int NUM_STAGES = 6;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic        [T_W-1:0]     param_t;

  // index 0 is x, index 1 is y
  typedef coord_t [1:0] pair_t;

  typedef struct packed {
    pair_t p0;
    pair_t p1;
    pair_t p2;
    pair_t p3;
  } cfg_t;

  // per-lerp stage load enables
  typedef struct packed {
    logic mul;
    logic add;
  } lerp_en_t;

endpackage

// ----- rtl/bezp_if.sv -----
// ----------------------------------------------------------------------------
// bezp request and result channels
// valid/ready channels carrying t requests and curve points
// ----------------------------------------------------------------------------
interface bezp_in_if;
  logic              valid;
  logic              ready;
  bezp_pkg::param_t  param_t;

  modport source (output valid, output param_t, input ready);
  modport sink   (input valid, input param_t, output ready);
endinterface

interface bezp_out_if;
  logic              valid;
  logic              ready;
  bezp_pkg::coord_t  point_x;
  bezp_pkg::coord_t  point_y;
  logic              cubic_mode;

  modport source (output valid, output point_x, output point_y, output cubic_mode,
                  input ready);
  modport sink   (input valid, input point_x, input point_y, input cubic_mode,
                  output ready);
endinterface

// ----- rtl/bezp_regs.sv -----
// ----------------------------------------------------------------------------
// bezp_regs
// apb register file holding the four curve points
// ----------------------------------------------------------------------------
module bezp_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bezp_pkg::ADDR_W-1:0]    paddr,
  input  logic [bezp_pkg::PDATA_W-1:0]   pwdata,
  output logic [bezp_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready,
  output bezp_pkg::cfg_t                 cfg_o
);

  bezp_pkg::coord_t                 regs_q [bezp_pkg::NUM_REGS];
  logic [bezp_pkg::IDX_W-1:0]       idx;
  logic                             wr_en;

  assign idx    = paddr[bezp_pkg::ADDR_W-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < bezp_pkg::NUM_REGS; i++) begin
        regs_q[i] <= '0;
      end
    end else if (wr_en) begin
      regs_q[idx] <= pwdata[bezp_pkg::COORD_W-1:0];
    end
  end

  // bits above the coordinate read as zero
  assign prdata = {{(bezp_pkg::PDATA_W-bezp_pkg::COORD_W){1'b0}}, regs_q[idx]};

  assign cfg_o.p0[0] = regs_q[bezp_pkg::REG_START_X];
  assign cfg_o.p0[1] = regs_q[bezp_pkg::REG_START_Y];
  assign cfg_o.p1[0] = regs_q[bezp_pkg::REG_CTRL1_X];
  assign cfg_o.p1[1] = regs_q[bezp_pkg::REG_CTRL1_Y];
  assign cfg_o.p2[0] = regs_q[bezp_pkg::REG_CTRL2_X];
  assign cfg_o.p2[1] = regs_q[bezp_pkg::REG_CTRL2_Y];
  assign cfg_o.p3[0] = regs_q[bezp_pkg::REG_END_X];
  assign cfg_o.p3[1] = regs_q[bezp_pkg::REG_END_Y];

endmodule

// ----- rtl/bezp_lerp.sv -----
// ----------------------------------------------------------------------------
// bezp_lerp
// two-stage linear interpolation a + round((b - a) * t), saturated
// ----------------------------------------------------------------------------
module bezp_lerp (
  input  logic               clk_i,
  input  bezp_pkg::lerp_en_t en_i,
  input  bezp_pkg::coord_t   a_i,
  input  bezp_pkg::coord_t   b_i,
  input  bezp_pkg::param_t   t_i,
  output bezp_pkg::coord_t   y_o
);

  localparam logic signed [bezp_pkg::PROD_W-1:0] Half =
    bezp_pkg::PROD_W'(1) <<< (bezp_pkg::T_FRAC - 1);

  logic signed [bezp_pkg::DIFF_W-1:0]  diff;
  logic signed [bezp_pkg::T_W:0]       t_s;
  logic signed [bezp_pkg::PROD_W-1:0]  prod_d, prod_q;
  bezp_pkg::coord_t                    a_q;
  logic signed [bezp_pkg::PROD_W-1:0]  biased;
  logic signed [bezp_pkg::SHIFT_W-1:0] rnd;
  logic signed [bezp_pkg::SUM_W-1:0]   sum;
  logic                                ovf;
  bezp_pkg::coord_t                    y_d, y_q;

  // multiply stage
  assign diff   = $signed({b_i[bezp_pkg::COORD_W-1], b_i})
                - $signed({a_i[bezp_pkg::COORD_W-1], a_i});
  assign t_s    = $signed({1'b0, t_i});
  assign prod_d = bezp_pkg::PROD_W'(diff) * bezp_pkg::PROD_W'(t_s);

  always_ff @(posedge clk_i) begin
    if (en_i.mul) begin
      prod_q <= prod_d;
      a_q    <= a_i;
    end
  end

  // round to nearest, ties up: floor((p + half) / 2^f)
  assign biased = prod_q + Half;
  assign rnd    = biased[bezp_pkg::PROD_W-1:bezp_pkg::T_FRAC];
  assign sum    = $signed({{(bezp_pkg::SUM_W-bezp_pkg::COORD_W){a_q[bezp_pkg::COORD_W-1]}}, a_q})
                + $signed({rnd[bezp_pkg::SHIFT_W-1], rnd});

  // saturate when the bits above the coordinate are not a sign copy
  assign ovf = ~((&sum[bezp_pkg::SUM_W-1:bezp_pkg::COORD_W-1]) |
                 ~(|sum[bezp_pkg::SUM_W-1:bezp_pkg::COORD_W-1]));

  always_comb begin
    if (ovf) begin
      y_d = sum[bezp_pkg::SUM_W-1] ? {1'b1, {(bezp_pkg::COORD_W-1){1'b0}}}
                                   : {1'b0, {(bezp_pkg::COORD_W-1){1'b1}}};
    end else begin
      y_d = sum[bezp_pkg::COORD_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.add) begin
      y_q <= y_d;
    end
  end

  assign y_o = y_q;

endmodule

// ----- rtl/bezier_point_evaluator_top.sv -----
// ----------------------------------------------------------------------------
// bezier_point_evaluator_top
// pipelined de casteljau evaluation of a quadratic or cubic 2d bezier point
// ----------------------------------------------------------------------------
// usage:
//   - program the points p0 (start), p1, p2 and p3 (end) over apb, byte
//     address 4*i for register i, while no request is in flight
//   - p2 all zero selects the quadratic curve through p0, p1 and p3
//   - each request on in_i carries t (unsigned, 1.0 = 2^16, larger clamps)
//   - each request gives exactly one point on out_o, in request order, with
//     cubic_mode telling which curve was evaluated
// timing:
//   - three lerp levels, each a multiply stage and a
//     round/add/saturate stage, one 17x18 multiplier per lerp
//   - throughput is one request per cycle while out_o is ready
// reset:
//   - all points clear to zero, the pipeline empties
// stalls:
//   - when out_o is not ready the last stage holds; bubbles in front of it
//     still fill, so requests keep being taken until every stage is occupied
// ----------------------------------------------------------------------------
module bezier_point_evaluator_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bezp_in_if.sink                       in_i,
  bezp_out_if.source                    out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bezp_pkg::ADDR_W-1:0]   paddr,
  input  logic [bezp_pkg::PDATA_W-1:0]  pwdata,
  output logic [bezp_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  localparam int NS = bezp_pkg::NUM_STAGES;

  bezp_pkg::cfg_t   cfg;

  // stage control: valid bits and per-stage load enables
  logic [NS-1:0]    valid_q;
  logic [NS-1:0]    rdy;

  // t and curve kind travel with the request
  bezp_pkg::param_t t_in;
  bezp_pkg::param_t t_q [4];
  logic             cubic_in;
  logic [NS-1:0]    cubic_q;

  // lerp outputs per level, x and y
  bezp_pkg::pair_t  l1a, l1b, l1c;
  bezp_pkg::pair_t  l2a, l2b;
  bezp_pkg::pair_t  l3;

  bezp_pkg::lerp_en_t en1, en2, en3;

  bezp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // a stage may load when it is empty or the stage after it moves on
  always_comb begin
    rdy[NS-1] = ~valid_q[NS-1] | out_o.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = ~valid_q[k] | rdy[k+1];
    end
  end

  assign in_i.ready = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (rdy[0]) begin
        valid_q[0] <= in_i.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // t above one clamps to exactly one
  assign t_in     = in_i.param_t[bezp_pkg::T_W-1]
                  ? {1'b1, {(bezp_pkg::T_W-1){1'b0}}} : in_i.param_t;
  assign cubic_in = |cfg.p2;

  // sideband registers, payload only
  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      t_q[0]     <= t_in;
      cubic_q[0] <= cubic_in;
    end
    for (int k = 1; k < 4; k++) begin
      if (rdy[k]) begin
        t_q[k] <= t_q[k-1];
      end
    end
    for (int k = 1; k < NS; k++) begin
      if (rdy[k]) begin
        cubic_q[k] <= cubic_q[k-1];
      end
    end
  end

  assign en1 = '{mul: rdy[0], add: rdy[1]};
  assign en2 = '{mul: rdy[2], add: rdy[3]};
  assign en3 = '{mul: rdy[4], add: rdy[5]};

  for (genvar ax = 0; ax < 2; ax++) begin : g_axis
    // level 1: quadratic reuses the middle lerp toward p3
    bezp_lerp u_l1a (
      .clk_i (clk_i), .en_i (en1), .a_i (cfg.p0[ax]), .b_i (cfg.p1[ax]),
      .t_i (t_in), .y_o (l1a[ax])
    );
    bezp_lerp u_l1b (
      .clk_i (clk_i), .en_i (en1), .a_i (cfg.p1[ax]),
      .b_i (cubic_in ? cfg.p2[ax] : cfg.p3[ax]),
      .t_i (t_in), .y_o (l1b[ax])
    );
    bezp_lerp u_l1c (
      .clk_i (clk_i), .en_i (en1), .a_i (cfg.p2[ax]), .b_i (cfg.p3[ax]),
      .t_i (t_in), .y_o (l1c[ax])
    );

    // level 2: for quadratic both lerps give the final point, so level 3
    // interpolates between equal values and passes it through unchanged
    bezp_lerp u_l2a (
      .clk_i (clk_i), .en_i (en2), .a_i (l1a[ax]), .b_i (l1b[ax]),
      .t_i (t_q[1]), .y_o (l2a[ax])
    );
    bezp_lerp u_l2b (
      .clk_i (clk_i), .en_i (en2),
      .a_i (cubic_q[1] ? l1b[ax] : l1a[ax]),
      .b_i (cubic_q[1] ? l1c[ax] : l1b[ax]),
      .t_i (t_q[1]), .y_o (l2b[ax])
    );

    // level 3: final lerp, its result register is the output register
    bezp_lerp u_l3 (
      .clk_i (clk_i), .en_i (en3), .a_i (l2a[ax]), .b_i (l2b[ax]),
      .t_i (t_q[3]), .y_o (l3[ax])
    );
  end

  assign out_o.valid      = valid_q[NS-1];
  assign out_o.point_x    = l3[0];
  assign out_o.point_y    = l3[1];
  assign out_o.cubic_mode = cubic_q[NS-1];

endmodule

// ----- bench/tb_bezier_point_evaluator_top.sv -----
// ----------------------------------------------------------------------------
// tb_bezier_point_evaluator_top
// self-checking bench for the pipelined bezier point evaluator: points are
// programmed over apb, t requests stream in with random gaps, and every curve
// point coming out is compared against a de casteljau model kept in the bench
// ----------------------------------------------------------------------------
module tb_bezier_point_evaluator_top;
  import bezp_pkg::*;

  // 1.0 in the t format, and the length of the forced output stall
  localparam longint T_ONE     = longint'(1) <<< T_FRAC;
  localparam int     LONG_HOLD = 400;
  localparam int     RAND_SETS = 16;
  localparam int     SET_ITEMS = 100;

  // one expected curve point
  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   cubic;
  } point_exp_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  bezp_in_if  req_if ();
  bezp_out_if pt_if ();

  bezier_point_evaluator_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (req_if),
    .out_o   (pt_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk_i = ~clk_i;

  // bench copy of the point registers, indexed by register code
  coord_t     ctl_pts [NUM_REGS];
  // t values still to be offered, and curve points still owed by the block
  param_t     t_backlog [$];
  point_exp_t points_due [$];

  bit req_live    = 1'b0; // a request is on the bus, waiting for ready
  int idle_pct    = 17;   // chance in percent that a side idles this cycle
  int hold_asked  = 0;    // long output stalls requested by the sequence
  int hold_given  = 0;    // long output stalls started by the receiver
  int hold_left   = 0;
  int fail_cnt    = 0;

  // ------------------------------------------------------------------------
  // curve model
  // ------------------------------------------------------------------------

  // a + round((b - a) * t / 2^T_FRAC), ties up, saturated to the coord range
  function automatic longint lerp_q(input longint a, input longint b, input longint t);
    longint hi;
    longint lo;
    longint s;
    hi = (longint'(1) <<< (COORD_W - 1)) - 1;
    lo = -hi - 1;
    s  = a + (((b - a) * t + (T_ONE >>> 1)) >>> T_FRAC);
    if (s > hi) s = hi;
    else if (s < lo) s = lo;
    return s;
  endfunction

  // one coordinate axis of the curve, three lerp levels for cubic, two for quadratic
  function automatic coord_t curve_axis(input longint p0, input longint p1, input longint p2,
                                        input longint p3, input bit cubic, input longint t);
    longint a;
    longint b;
    longint c;
    longint ab;
    longint bc;
    if (cubic) begin
      a  = lerp_q(p0, p1, t);
      b  = lerp_q(p1, p2, t);
      c  = lerp_q(p2, p3, t);
      ab = lerp_q(a, b, t);
      bc = lerp_q(b, c, t);
      return coord_t'(lerp_q(ab, bc, t));
    end
    a = lerp_q(p0, p1, t);
    b = lerp_q(p1, p3, t);
    return coord_t'(lerp_q(a, b, t));
  endfunction

  function automatic point_exp_t predict_point(input param_t raw_t);
    point_exp_t pt;
    longint     t;
    // anything past 1.0 clamps to the end point
    t        = (longint'(raw_t) > T_ONE) ? T_ONE : longint'(raw_t);
    // p2 at the origin selects the quadratic curve
    pt.cubic = (ctl_pts[REG_CTRL2_X] != 0) || (ctl_pts[REG_CTRL2_Y] != 0);
    pt.x     = curve_axis(ctl_pts[REG_START_X], ctl_pts[REG_CTRL1_X], ctl_pts[REG_CTRL2_X],
                          ctl_pts[REG_END_X], pt.cubic, t);
    pt.y     = curve_axis(ctl_pts[REG_START_Y], ctl_pts[REG_CTRL1_Y], ctl_pts[REG_CTRL2_Y],
                          ctl_pts[REG_END_Y], pt.cubic, t);
    return pt;
  endfunction

  // ------------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------------

  // corner t values: zero, one lsb, around one half, around 1.0, past 1.0
  function automatic param_t corner_t(input int i);
    case (i)
      0:       return param_t'(0);
      1:       return param_t'(1);
      2:       return param_t'(32767);
      3:       return param_t'(32768);
      4:       return param_t'(32769);
      5:       return param_t'(65535);
      6:       return param_t'(65536);
      7:       return param_t'(65537);
      8:       return param_t'(98304);
      default: return param_t'(131071);
    endcase
  endfunction

  // random t, weighted toward the ends of the range and past 1.0
  function automatic param_t rand_t();
    case ($urandom_range(9))
      0:       return param_t'(0);
      1:       return param_t'(T_ONE);
      2:       return param_t'($urandom_range(131071, 65537));
      3:       return param_t'($urandom_range(3));
      4:       return param_t'(T_ONE - $urandom_range(3));
      default: return param_t'($urandom_range(65536));
    endcase
  endfunction

  // random coordinate, with the full-scale values and zero showing up often
  function automatic coord_t pick_coord();
    case ($urandom_range(9))
      0:       return coord_t'(-32768);
      1:       return coord_t'(32767);
      2:       return coord_t'(0);
      3:       return coord_t'($urandom_range(8)) - coord_t'(4);
      default: return coord_t'($urandom);
    endcase
  endfunction

  // apb write: setup then access, the register takes the value when pready is seen
  task automatic write_reg(input logic [IDX_W-1:0] idx, input coord_t val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    // upper bits carry junk, the block keeps only the coordinate width
    pwdata  <= {16'($urandom), val};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    ctl_pts[idx] = val;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_points(input coord_t sx, input coord_t sy, input coord_t c1x,
                            input coord_t c1y, input coord_t c2x, input coord_t c2y,
                            input coord_t ex, input coord_t ey);
    write_reg(REG_START_X, sx);
    write_reg(REG_START_Y, sy);
    write_reg(REG_CTRL1_X, c1x);
    write_reg(REG_CTRL1_Y, c1y);
    write_reg(REG_CTRL2_X, c2x);
    write_reg(REG_CTRL2_Y, c2y);
    write_reg(REG_END_X, ex);
    write_reg(REG_END_Y, ey);
  endtask

  // sender stops until every owed point is back, then the pipe gets time to settle
  task automatic wait_drained();
    while (t_backlog.size() != 0 || req_live || points_due.size() != 0) @(posedge clk_i);
    repeat (NUM_STAGES + 2) @(posedge clk_i);
  endtask

  task automatic report_mismatch(input string what);
    fail_cnt++;
    $display("mismatch: %s", what);
  endtask

  // ------------------------------------------------------------------------
  // request driver: offers the oldest t, holds it until taken
  // ------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!req_live) begin
      if (rst_ni && t_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
        req_if.valid   <= 1'b1;
        req_if.param_t <= t_backlog[0];
        req_live = 1'b1;
      end else begin
        // idle cycle, data lines carry noise
        req_if.valid   <= 1'b0;
        req_if.param_t <= param_t'($urandom);
      end
    end
  end

  // request taken: retire it from the backlog and predict its point
  always @(posedge clk_i) begin
    if (rst_ni && req_if.valid && req_if.ready) begin
      void'(t_backlog.pop_front());
      points_due.push_back(predict_point(req_if.param_t));
      req_live = 1'b0;
    end
  end

  // ------------------------------------------------------------------------
  // point receiver: random back-pressure, plus a long stall on request
  // ------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (hold_given != hold_asked) begin
      hold_given++;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      pt_if.ready <= 1'b0;
    end else begin
      pt_if.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // point monitor: each point taken is checked against the oldest prediction
  always @(posedge clk_i) begin
    point_exp_t want;
    if (rst_ni && pt_if.valid && pt_if.ready) begin
      if (points_due.size() == 0) begin
        report_mismatch($sformatf("point (%0d,%0d) with no request outstanding",
                                  pt_if.point_x, pt_if.point_y));
      end else begin
        want = points_due.pop_front();
        if (pt_if.point_x !== want.x)
          report_mismatch($sformatf("point_x got %0d want %0d", pt_if.point_x, want.x));
        if (pt_if.point_y !== want.y)
          report_mismatch($sformatf("point_y got %0d want %0d", pt_if.point_y, want.y));
        if (pt_if.cubic_mode !== want.cubic)
          report_mismatch($sformatf("cubic_mode got %b want %b", pt_if.cubic_mode,
                                    want.cubic));
      end
    end
  end

  // ------------------------------------------------------------------------
  // sequence
  // ------------------------------------------------------------------------
  initial begin
    int     k;
    int     n;
    coord_t c2x;
    coord_t c2y;

    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    req_if.valid   = 1'b0;
    req_if.param_t = '0;
    pt_if.ready    = 1'b0;
    foreach (ctl_pts[i]) ctl_pts[i] = '0;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // points still at reset: quadratic through the origin
    t_backlog.push_back(corner_t(0));
    t_backlog.push_back(corner_t(6));
    t_backlog.push_back(corner_t(9));
    wait_drained();

    // cubic with every point at full scale, alternating sign, over the t corners
    set_points(-32768, 32767, 32767, -32768, -32768, 32767, 32767, -32768);
    for (n = 0; n < 10; n++) t_backlog.push_back(corner_t(n));
    wait_drained();

    // quadratic at full scale
    set_points(32767, -32768, -32768, 32767, 0, 0, 32767, 32767);
    for (n = 0; n < 10; n += 1) begin
      if (n != 1 && n != 4) t_backlog.push_back(corner_t(n));
    end
    wait_drained();

    // random point sets: quadratic, cubic with one zero p2 coordinate, free cubic
    for (k = 0; k < RAND_SETS; k++) begin
      c2x = pick_coord();
      c2y = pick_coord();
      case (k % 4)
        0: begin
          c2x = '0;
          c2y = '0;
        end
        1: begin
          c2x = '0;
          if (c2y == 0) c2y = coord_t'(1);
        end
        2: begin
          c2y = '0;
          if (c2x == 0) c2x = coord_t'(-1);
        end
        default: ;
      endcase
      set_points(pick_coord(), pick_coord(), pick_coord(), pick_coord(), c2x, c2y,
                 pick_coord(), pick_coord());

      // one set runs with no idling at all on either side
      idle_pct = (k == 5) ? 0 : 17;
      for (n = 0; n < SET_ITEMS; n++) t_backlog.push_back(rand_t());
      // one set sees the output stall long enough to back up into the input
      if (k == 2) hold_asked++;
      wait_drained();
    end

    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/bezp_pkg.sv
rtl/bezp_if.sv
rtl/bezp_regs.sv
rtl/bezp_lerp.sv
rtl/bezier_point_evaluator_top.sv
bench/tb_bezier_point_evaluator_top.sv
